[rtl/ghm_pkg.sv]
`timescale 1ns / 1ps
// ghm_pkg: shared types, codes, constants and the elaboration-time weight table
// for the Gaussian splat heatmap. No dependencies.
package ghm_pkg;

	// Weight table: depth is fixed (power of two), Q0.8 entries
	localparam int WTAB_DEPTH = 256;
	localparam int WTAB_AW    = $clog2(WTAB_DEPTH);

	// Signed width of a mapped cell coordinate
	localparam int CW = 33;

	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [14:0] GAMMA_Q16 = 15'd22938;

	// APB register map
	localparam int APB_AW = 5;
	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Z  = 3'd1,
		REG_CPU_X     = 3'd2,
		REG_CPU_Z     = 3'd3,
		REG_REACH     = 3'd4,
		REG_INV_RSQ   = 3'd5,
		REG_WIN_START = 3'd6,
		REG_WIN_END   = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_SPLAT = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_SPLAT = 2'd1,
		CMD_READ  = 2'd2,
		CMD_REPLY = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t              op;
		logic                 acc;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cz;
		logic [15:0]          cell_idx;
	} cmd_t;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_z;
		logic [23:0] cpu_x;
		logic [23:0] cpu_z;
		logic [3:0]  reach;
		logic [23:0] inv_rsq;
		logic [31:0] win_start;
		logic [31:0] win_end;
	} cfg_t;

	typedef struct packed {
		logic init_busy;
	} bk_status_t;

	typedef enum logic [3:0] {
		B_IDLE, B_CLEAR, B_SETUP, B_SRD, B_SWR, B_RRD, B_RSTART, B_SHAPE, B_OUT
	} bk_state_t;

	typedef enum logic [3:0] {
		M_IDLE, M_DIV, M_NORM, M_LOG, M_GAMMA, M_SCALE, M_TMUL, M_SQR, M_FIN, M_DONE
	} mt_state_t;

	// exp(-x), x and result in Q32; elaboration use only
	function automatic logic [63:0] exp_neg_q32(input logic [63:0] x);
		logic [63:0] y;
		logic [63:0] term;
		logic [63:0] v;
		longint      sum;
		y    = x >> 5;
		term = 64'h1_0000_0000;
		sum  = 64'sh1_0000_0000;
		for (int k = 1; k <= 10; k++) begin
			term = ((term * y) >> 32) / 64'(k);
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		v = 64'(sum);
		for (int s = 0; s < 5; s++) begin
			if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
			v = (v * v) >> 32;
		end
		return v;
	endfunction

	function automatic logic [WTAB_DEPTH*8-1:0] build_wtab();
		logic [WTAB_DEPTH*8-1:0] t;
		logic [63:0]             x;
		logic [63:0]             w;
		t = '0;
		for (int i = 0; i < WTAB_DEPTH; i++) begin
			x = ((64'd7 << 31) * 64'(i)) / WTAB_DEPTH;
			w = (exp_neg_q32(x) * 64'd256 + 64'h8000_0000) >> 32;
			t[i*8 +: 8] = (w > 64'd255) ? 8'd255 : w[7:0];
		end
		return t;
	endfunction

	localparam logic [WTAB_DEPTH*8-1:0] WTAB = build_wtab();

endpackage

[rtl/ghm_fifo.sv]
`timescale 1ns / 1ps
// ghm_fifo: two-entry command queue between the front and back parts.
// No package dependencies.
module ghm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);
	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end
endmodule

[rtl/ghm_front.sv]
`timescale 1ns / 1ps
// ghm_front: accepts input transfers, checks window and range, maps the
// sample to a grid cell and pushes a command. Depends on ghm_pkg.
module ghm_front #(
	parameter int GRID_SIDE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghm_pkg::cfg_t       cfg,
	input  ghm_pkg::bk_status_t status,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_kind,
	input  logic [31:0]         pos_x,
	input  logic [31:0]         pos_z,
	input  logic [31:0]         time_ms,
	input  logic [15:0]         cell_index,
	output logic                push_valid,
	input  logic                push_ready,
	output ghm_pkg::cmd_t       push_cmd
);
	import ghm_pkg::*;

	localparam int CELLS = GRID_SIDE * GRID_SIDE;

	logic               valid_s1;
	kind_t              kind_s1;
	logic [31:0]        mag_x_s1, mag_z_s1;
	logic               neg_x_s1, neg_z_s1;
	logic               in_win_s1, cell_ok_s1;
	logic [15:0]        cell_s1;

	logic signed [32:0] diff_x, diff_z;
	logic [55:0]        prod_x, prod_z;
	logic [CW-1:0]      cx, cz;
	logic               take;

	assign in_ready   = !status.init_busy && (!valid_s1 || push_ready);
	assign take       = in_valid && in_ready;
	assign push_valid = valid_s1;

	assign diff_x = $signed({pos_x[31], pos_x}) - $signed({cfg.origin_x[31], cfg.origin_x});
	assign diff_z = $signed({pos_z[31], pos_z}) - $signed({cfg.origin_z[31], cfg.origin_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1    <= kind_t'(in_kind);
			neg_x_s1   <= diff_x[32];
			neg_z_s1   <= diff_z[32];
			mag_x_s1   <= diff_x[32] ? 32'(-diff_x) : diff_x[31:0];
			mag_z_s1   <= diff_z[32] ? 32'(-diff_z) : diff_z[31:0];
			in_win_s1  <= (time_ms >= cfg.win_start) && (time_ms <= cfg.win_end);
			cell_ok_s1 <= (32'(cell_index) < 32'(CELLS));
			cell_s1    <= cell_index;
		end
	end

	// truncation toward zero: scale the magnitude, then restore the sign
	assign prod_x = 56'(mag_x_s1) * 56'(cfg.cpu_x);
	assign prod_z = 56'(mag_z_s1) * 56'(cfg.cpu_z);
	assign cx = neg_x_s1 ? CW'(-{1'b0, prod_x[55:24]}) : {1'b0, prod_x[55:24]};
	assign cz = neg_z_s1 ? CW'(-{1'b0, prod_z[55:24]}) : {1'b0, prod_z[55:24]};

	always_comb begin
		push_cmd          = '0;
		push_cmd.cx       = cx;
		push_cmd.cz       = cz;
		push_cmd.cell_idx = cell_s1;
		unique case (kind_s1)
			KIND_CLEAR: begin
				push_cmd.op  = CMD_CLEAR;
				push_cmd.acc = 1'b1;
			end
			KIND_SPLAT: begin
				push_cmd.op  = in_win_s1 ? CMD_SPLAT : CMD_REPLY;
				push_cmd.acc = 1'b0;
			end
			KIND_READ: begin
				push_cmd.op  = cell_ok_s1 ? CMD_READ : CMD_REPLY;
				push_cmd.acc = 1'b0;
			end
			default: begin
				push_cmd.op  = CMD_REPLY;
				push_cmd.acc = 1'b0;
			end
		endcase
	end
endmodule

[rtl/ghm_math.sv]
`timescale 1ns / 1ps
// ghm_math: iterative shaping unit, (raw/peak)^0.35 in Q0.16, via a shared
// restoring divider, log2 by squaring and exp by series. Depends on ghm_pkg.
module ghm_math (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] raw,
	input  logic [23:0] peak,
	output logic        done,
	output logic [15:0] shaped
);
	import ghm_pkg::*;

	mt_state_t          state_q, state_d;
	logic [23:0]        rem_q, div_q;
	logic [31:0]        dvd_q, quo_q;
	logic [4:0]         cnt_q;
	logic               div_term_q;
	logic [31:0]        z_q;
	logic [4:0]         ip_q;
	logic [15:0]        frac_q;
	logic [19:0]        m_q;
	logic [30:0]        y_q;
	logic [32:0]        term_q;
	logic signed [34:0] sum_q;
	logic [3:0]         k_q;
	logic [32:0]        v_q;
	logic [15:0]        res_q;

	logic [24:0]        rem_sh;
	logic               rem_ge;
	logic [23:0]        rem_nx;
	logic [31:0]        quo_nx;
	logic [63:0]        zz;
	logic [32:0]        zt;
	logic [21:0]        n_val;
	logic [37:0]        m_full;
	logic [51:0]        x_full;
	logic [63:0]        tp;
	logic signed [34:0] sum_nx;
	logic [31:0]        v_sat;
	logic [63:0]        vv;
	logic [16:0]        r_full;

	// one divider step
	assign rem_sh = {rem_q, dvd_q[31]};
	assign rem_ge = (rem_sh >= {1'b0, div_q});
	assign rem_nx = rem_ge ? 24'(rem_sh - {1'b0, div_q}) : rem_sh[23:0];
	assign quo_nx = {quo_q[30:0], rem_ge};

	// one log2 fraction bit
	assign zz = 64'(z_q) * 64'(z_q);
	assign zt = zz[63:31];

	assign n_val  = 22'(32'd32 << 16) - 22'({ip_q, frac_q});
	assign m_full = 38'(n_val) * 38'(GAMMA_Q16) + 38'd32768;
	assign x_full = 52'(m_q) * 52'(LN2_Q32);
	assign tp     = 64'(term_q) * 64'(y_q);
	assign sum_nx = k_q[0] ? sum_q - $signed({3'b000, quo_nx}) : sum_q + $signed({3'b000, quo_nx});
	assign v_sat  = (v_q > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : v_q[31:0];
	assign vv     = 64'(v_sat) * 64'(v_sat);
	assign r_full = 17'((v_q + 33'd32768) >> 16);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: begin
				if (start) begin
					if (raw == 24'd0 || peak == 24'd0 || raw >= peak) state_d = M_DONE;
					else state_d = M_DIV;
				end
			end
			M_DIV: begin
				if (cnt_q == 5'd0) begin
					if (div_term_q) state_d = (k_q == 4'd10) ? M_SQR : M_TMUL;
					else state_d = (quo_nx == 32'd0) ? M_DONE : M_NORM;
				end
			end
			M_NORM:  if (z_q[31]) state_d = M_LOG;
			M_LOG:   if (cnt_q == 5'd0) state_d = M_GAMMA;
			M_GAMMA: state_d = M_SCALE;
			M_SCALE: state_d = M_TMUL;
			M_TMUL:  state_d = M_DIV;
			M_SQR:   if (cnt_q == 5'd0) state_d = M_FIN;
			M_FIN:   state_d = M_DONE;
			M_DONE:  state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == M_DONE);
		shaped = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= M_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				rem_q      <= raw;
				div_q      <= peak;
				dvd_q      <= 32'd0;
				quo_q      <= 32'd0;
				cnt_q      <= 5'd31;
				div_term_q <= 1'b0;
				ip_q       <= 5'd31;
				res_q      <= (raw == 24'd0 || peak == 24'd0) ? 16'd0 : 16'hFFFF;
			end
			M_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[30:0], 1'b0};
				quo_q <= quo_nx;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					if (div_term_q) begin
						term_q <= {1'b0, quo_nx};
						sum_q  <= sum_nx;
						k_q    <= k_q + 4'd1;
						v_q    <= sum_nx[34] ? 33'd0 : sum_nx[32:0];
						cnt_q  <= 5'd4;
					end else begin
						z_q   <= quo_nx;
						res_q <= 16'd0;
					end
				end
			end
			M_NORM: begin
				frac_q <= 16'd0;
				cnt_q  <= 5'd15;
				if (!z_q[31]) begin
					z_q  <= {z_q[30:0], 1'b0};
					ip_q <= ip_q - 5'd1;
				end
			end
			M_LOG: begin
				frac_q <= {frac_q[14:0], zt[32]};
				z_q    <= zt[32] ? zt[32:1] : zt[31:0];
				cnt_q  <= cnt_q - 5'd1;
			end
			M_GAMMA: m_q <= m_full[35:16];
			M_SCALE: begin
				y_q    <= x_full[51:21];
				term_q <= 33'h1_0000_0000;
				sum_q  <= 35'sh1_0000_0000;
				k_q    <= 4'd1;
			end
			M_TMUL: begin
				rem_q      <= 24'd0;
				div_q      <= 24'(k_q);
				dvd_q      <= tp[63:32];
				quo_q      <= 32'd0;
				cnt_q      <= 5'd31;
				div_term_q <= 1'b1;
			end
			M_SQR: begin
				v_q   <= {1'b0, vv[63:32]};
				cnt_q <= cnt_q - 5'd1;
			end
			M_FIN:   res_q <= r_full[16] ? 16'hFFFF : r_full[15:0];
			default: ;
		endcase
	end
endmodule

[rtl/ghm_back.sv]
`timescale 1ns / 1ps
// ghm_back: executes commands against the density grid memory: clear sweep,
// kernel read-modify-write walk, cell read with shaping, result register.
// Depends on ghm_pkg and ghm_math.
module ghm_back #(
	parameter int GRID_SIDE = 256,
	parameter int MAX_REACH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghm_pkg::cfg_t       cfg,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  ghm_pkg::cmd_t       cmd,
	output ghm_pkg::bk_status_t status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         out_raw,
	output logic [15:0]         out_shaped,
	output logic                out_acc
);
	import ghm_pkg::*;

	localparam int CELLS   = GRID_SIDE * GRID_SIDE;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int SIDE_W  = $clog2(GRID_SIDE);
	localparam int RW      = $clog2(MAX_REACH + 1);
	localparam int SQW     = 2 * RW + 1;
	localparam int BW      = CW + 3;

	bk_state_t          state_q, state_d;
	logic               reply_q;
	logic [CELL_AW-1:0] clr_idx_q;
	logic [23:0]        peak_q;
	cmd_t               cmd_q;
	logic [SIDE_W-1:0]  px0_q, px1_q, pz1_q, px_q, pz_q;
	logic [WTAB_AW-1:0] idx_s1;
	logic               skip_s1;
	logic [CELL_AW-1:0] addr_s1;
	logic [23:0]        res_raw_q;
	logic [15:0]        res_shaped_q;
	logic               res_acc_q;
	logic               out_valid_q;
	logic [23:0]        out_raw_q;
	logic [15:0]        out_shaped_q;
	logic               out_acc_q;

	logic [23:0]        grid_mem [CELLS];
	logic [23:0]        rdata_q;
	logic               rd_en;
	logic [CELL_AW-1:0] rd_addr;
	logic               wr_en;
	logic [CELL_AW-1:0] wr_addr;
	logic [23:0]        wr_data;

	logic [RW-1:0]        r_eff;
	logic signed [BW-1:0] cxe, cze, r_s, lox, hix, loz, hiz, x0, x1, z0, z1, gmax;
	logic                 empty;
	logic signed [BW-1:0] dxs, dzs;
	logic [RW-1:0]        dx, dz;
	logic [SQW-1:0]       sq_sum;
	logic [SQW+23:0]      d2;
	logic [CELL_AW-1:0]   cur_addr;
	logic [31:0]          cell_ext;
	logic [7:0]           wt;
	logic [24:0]          wsum;
	logic [23:0]          v_new;
	logic                 last_cell;
	logic                 out_free;
	logic                 m_start, m_done;
	logic [15:0]          m_shaped;

	ghm_math u_math (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m_start),
		.raw    (rdata_q),
		.peak   (peak_q),
		.done   (m_done),
		.shaped (m_shaped)
	);

	// kernel bounds, clipped to the grid
	assign r_eff = (32'(cfg.reach) > MAX_REACH) ? RW'(MAX_REACH) : RW'(cfg.reach);
	assign cxe   = $signed({{(BW-CW){cmd_q.cx[CW-1]}}, cmd_q.cx});
	assign cze   = $signed({{(BW-CW){cmd_q.cz[CW-1]}}, cmd_q.cz});
	assign r_s   = $signed({{(BW-RW){1'b0}}, r_eff});
	assign gmax  = $signed(BW'(GRID_SIDE - 1));
	assign lox   = cxe - r_s;
	assign hix   = cxe + r_s;
	assign loz   = cze - r_s;
	assign hiz   = cze + r_s;
	assign x0    = (lox < 0) ? '0 : lox;
	assign x1    = (hix > gmax) ? gmax : hix;
	assign z0    = (loz < 0) ? '0 : loz;
	assign z1    = (hiz > gmax) ? gmax : hiz;
	assign empty = (x0 > x1) || (z0 > z1);

	// distance of the current cell from the kernel center
	assign dxs    = $signed({{(BW-SIDE_W){1'b0}}, px_q}) - cxe;
	assign dzs    = $signed({{(BW-SIDE_W){1'b0}}, pz_q}) - cze;
	assign dx     = dxs[BW-1] ? RW'(-dxs) : RW'(dxs);
	assign dz     = dzs[BW-1] ? RW'(-dzs) : RW'(dzs);
	assign sq_sum = SQW'(dx) * SQW'(dx) + SQW'(dz) * SQW'(dz);
	assign d2     = (SQW+24)'(sq_sum) * (SQW+24)'(cfg.inv_rsq);

	assign cur_addr = CELL_AW'(pz_q * GRID_SIDE + px_q);
	assign cell_ext = 32'(cmd_q.cell_idx);

	assign wt        = WTAB[{idx_s1, 3'b000} +: 8];
	assign wsum      = {1'b0, rdata_q} + 25'(wt);
	assign v_new     = wsum[24] ? 24'hFF_FFFF : wsum[23:0];
	assign last_cell = (px_q == px1_q) && (pz_q == pz1_q);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						CMD_CLEAR: state_d = B_CLEAR;
						CMD_SPLAT: state_d = B_SETUP;
						CMD_READ:  state_d = B_RRD;
						default:   state_d = B_OUT;
					endcase
				end
			end
			B_CLEAR:  if (32'(clr_idx_q) == CELLS - 1) state_d = reply_q ? B_OUT : B_IDLE;
			B_SETUP:  state_d = empty ? B_OUT : B_SRD;
			B_SRD:    state_d = B_SWR;
			B_SWR:    state_d = last_cell ? B_OUT : B_SRD;
			B_RRD:    state_d = B_RSTART;
			B_RSTART: state_d = B_SHAPE;
			B_SHAPE:  if (m_done) state_d = B_OUT;
			B_OUT:    if (out_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop          = (state_q == B_IDLE) && cmd_valid;
		status.init_busy = (state_q == B_CLEAR) && !reply_q;
		m_start          = (state_q == B_RSTART);
		rd_en            = (state_q == B_SRD) || (state_q == B_RRD);
		rd_addr          = (state_q == B_SRD) ? cur_addr : cell_ext[CELL_AW-1:0];
		wr_en            = (state_q == B_CLEAR) || ((state_q == B_SWR) && !skip_s1);
		wr_addr          = (state_q == B_CLEAR) ? clr_idx_q : addr_s1;
		wr_data          = (state_q == B_CLEAR) ? 24'd0 : v_new;
		out_valid        = out_valid_q;
		out_raw          = out_raw_q;
		out_shaped       = out_shaped_q;
		out_acc          = out_acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			reply_q     <= 1'b0;
			clr_idx_q   <= '0;
			peak_q      <= 24'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_IDLE && cmd_valid && cmd.op == CMD_CLEAR) begin
				reply_q   <= 1'b1;
				clr_idx_q <= '0;
				peak_q    <= 24'd0;
			end
			if (state_q == B_CLEAR) clr_idx_q <= clr_idx_q + CELL_AW'(1);
			if (state_q == B_SWR && !skip_s1 && v_new > peak_q) peak_q <= v_new;
			if (state_q == B_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_q        <= cmd;
					res_raw_q    <= 24'd0;
					res_shaped_q <= 16'd0;
					res_acc_q    <= (cmd.op == CMD_REPLY) ? cmd.acc : 1'b1;
				end
			end
			B_SETUP: begin
				px0_q <= SIDE_W'(x0);
				px1_q <= SIDE_W'(x1);
				pz1_q <= SIDE_W'(z1);
				px_q  <= SIDE_W'(x0);
				pz_q  <= SIDE_W'(z0);
			end
			B_SRD: begin
				skip_s1 <= (d2[SQW+23:16] != '0);
				idx_s1  <= d2[15 -: WTAB_AW];
				addr_s1 <= cur_addr;
			end
			B_SWR: begin
				if (px_q == px1_q) begin
					px_q <= px0_q;
					pz_q <= pz_q + SIDE_W'(1);
				end else begin
					px_q <= px_q + SIDE_W'(1);
				end
			end
			B_RSTART: res_raw_q <= rdata_q;
			B_SHAPE:  if (m_done) res_shaped_q <= m_shaped;
			B_OUT: begin
				if (out_free) begin
					out_raw_q    <= res_raw_q;
					out_shaped_q <= res_shaped_q;
					out_acc_q    <= res_acc_q;
				end
			end
			default: ;
		endcase
	end

	// grid memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) grid_mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= grid_mem[rd_addr];
	end
endmodule

[rtl/gaussian_splat_heatmap_top.sv]
`timescale 1ns / 1ps
// gaussian_splat_heatmap_top: APB register file, front/back parts and the
// command queue. Depends on ghm_pkg, ghm_front, ghm_fifo, ghm_back.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready | tdata: pos_x, pos_z, time_ms, cell_index
//          |     |                   | tuser: kind
//  m_*     | out | m_tvalid/m_tready | tdata: raw_level, shaped_level
//          |     |                   | tuser: accepted
//  APB     | in  | psel/penable      | 8 registers at 4*i, pready tied high
//
// Per item: a splat reads and then writes each kernel cell, up to (2R+1)^2
// cells, through the registered read port and the write port of the grid memory.
// A clear sweeps the memory at one cell a cycle. A read runs the shaping unit
// (32-step divide, log by 16 squarings, 10 series terms each with a 32-step
// divide, 5 squarings).
// After reset the same clear sweep runs and s_tready stays low until it ends.
// The result register lets the front take the next transfer while a result
// waits on m_tready.
module gaussian_splat_heatmap_top #(
	parameter int GRID_SIDE = 256,
	parameter int MAX_REACH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// stream in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [111:0]               s_tdata,  // pos_x[31:0], pos_z[63:32],
	                                             // time_ms[95:64], cell_index[111:96]
	input  logic [1:0]                 s_tuser,  // kind[1:0]
	// stream out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // raw_level[23:0], shaped_level[39:24]
	output logic [0:0]                 m_tuser,  // accepted[0]
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ghm_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ghm_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   reg_sel;
	logic       cfg_wr;
	bk_status_t bk_status;

	logic       push_valid, push_ready;
	cmd_t       push_cmd;
	logic       q_valid, q_pop;
	cmd_t       q_cmd;
	logic [23:0] out_raw;
	logic [15:0] out_shaped;
	logic        out_acc;

	// ---------------- APB register file ----------------
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= 32'd0;
			cfg_q.origin_z  <= 32'd0;
			cfg_q.cpu_x     <= 24'd65536;
			cfg_q.cpu_z     <= 24'd65536;
			cfg_q.reach     <= 4'd4;
			cfg_q.inv_rsq   <= 24'd4096;
			cfg_q.win_start <= 32'd0;
			cfg_q.win_end   <= 32'hFFFF_FFFF;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ORIGIN_X:  cfg_q.origin_x  <= pwdata;
				REG_ORIGIN_Z:  cfg_q.origin_z  <= pwdata;
				REG_CPU_X:     cfg_q.cpu_x     <= pwdata[23:0];
				REG_CPU_Z:     cfg_q.cpu_z     <= pwdata[23:0];
				REG_REACH:     cfg_q.reach     <= pwdata[3:0];
				REG_INV_RSQ:   cfg_q.inv_rsq   <= pwdata[23:0];
				REG_WIN_START: cfg_q.win_start <= pwdata;
				REG_WIN_END:   cfg_q.win_end   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ORIGIN_X:  prdata = cfg_q.origin_x;
			REG_ORIGIN_Z:  prdata = cfg_q.origin_z;
			REG_CPU_X:     prdata = 32'(cfg_q.cpu_x);
			REG_CPU_Z:     prdata = 32'(cfg_q.cpu_z);
			REG_REACH:     prdata = 32'(cfg_q.reach);
			REG_INV_RSQ:   prdata = 32'(cfg_q.inv_rsq);
			REG_WIN_START: prdata = cfg_q.win_start;
			REG_WIN_END:   prdata = cfg_q.win_end;
			default:       prdata = 32'd0;
		endcase
	end

	// ---------------- front: classify and map ----------------
	ghm_front #(
		.GRID_SIDE (GRID_SIDE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.status     (bk_status),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.pos_x      (s_tdata[31:0]),
		.pos_z      (s_tdata[63:32]),
		.time_ms    (s_tdata[95:64]),
		.cell_index (s_tdata[111:96]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// ---------------- command queue ----------------
	ghm_fifo #(
		.W ($bits(cmd_t))
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_cmd)
	);

	// ---------------- back: grid engine ----------------
	ghm_back #(
		.GRID_SIDE (GRID_SIDE),
		.MAX_REACH (MAX_REACH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (q_valid),
		.cmd_pop    (q_pop),
		.cmd        (q_cmd),
		.status     (bk_status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_raw    (out_raw),
		.out_shaped (out_shaped),
		.out_acc    (out_acc)
	);

	assign m_tdata = {out_shaped, out_raw};
	assign m_tuser = out_acc;
endmodule

[rtl/ghm_checker.sv]
`timescale 1ns / 1ps
// ghm_checker: port-level assertions for gaussian_splat_heatmap_top, bound
// to the top level below. Depends on ghm_pkg.
module ghm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [39:0]                m_tdata,
	input logic [0:0]                 m_tuser,
	input logic                       pready,
	input logic [ghm_pkg::APB_AW-1:0] paddr
);
	import ghm_pkg::*;

	// a stalled result transfer keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// rejected items carry no levels
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
		else $error("rejected item with nonzero levels");

	// an empty cell never gets a shaped level
	a_shape_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23:0] == 24'd0 |-> m_tdata[39:24] == 16'd0)
		else $error("shaped level without raw level");

	// configuration port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		$stable(paddr) || !$stable(paddr) |-> pready)
		else $error("pready low");
endmodule

bind gaussian_splat_heatmap_top ghm_checker u_ghm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready),
	.paddr    (paddr)
);
